// ===== hw/rtl/median_filter_3x3_rgb_top_macros.svh =====
// assertion macros shared by the median filter modules
`ifndef MEDIAN_FILTER_3X3_RGB_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_RGB_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define MF3_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// consequence in the same cycle
`define MF3_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define MF3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mf3_pkg.sv =====
// types, constants and compare functions of the 3x3 rgb median filter
package mf3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MIN_SIZE    = 3;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SZ_COL_W    = COL_W + 1;
    localparam int SZ_ROW_W    = ROW_W + 1;

    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam int CH_W   = 8;
    localparam int N_CH   = 3;
    localparam int PIX_W  = CH_W * N_CH;
    localparam int WIN_N  = 9;
    localparam int LS_W   = 2 * PIX_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CH_W-1:0] t_chan;
    // channel 0 blue, 1 green, 2 red
    typedef t_chan [N_CH-1:0] t_pix;
    // entry 0 lowest, entry 2 highest
    typedef t_chan [2:0] t_trio;

    // window: 0..2 column c-2, 3..5 column c-1, 6..8 column c, rows top to bottom
    typedef struct packed {
        logic                last;
        t_pix [WIN_N-1:0]    px;
    } t_win;

    function automatic t_chan min2(input t_chan a, input t_chan b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_chan max2(input t_chan a, input t_chan b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_chan min3(input t_chan a, input t_chan b, input t_chan c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_chan max3(input t_chan a, input t_chan b, input t_chan c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_chan med3(input t_chan a, input t_chan b, input t_chan c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trio sort3(input t_chan a, input t_chan b, input t_chan c);
        t_chan lo1;
        t_chan hi1;
        t_chan lo2;
        t_trio res;
        lo1    = min2(a, b);
        hi1    = max2(a, b);
        lo2    = min2(hi1, c);
        res[2] = max2(hi1, c);
        res[1] = max2(lo1, lo2);
        res[0] = min2(lo1, lo2);
        return res;
    endfunction

endpackage

// ===== hw/rtl/mf3_ram.sv =====
// generic single write port ram with registered read
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mf3_front.sv =====
// front end: position tracking, line stores, column window and window push
`include "median_filter_3x3_rgb_top_macros.svh"

module mf3_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  mf3_pkg::t_pix                   i_pix,
    input  logic                            i_frame_start,
    input  logic [mf3_pkg::QCNT_W-1:0]      i_q_count,
    output logic                            o_push,
    output mf3_pkg::t_win                   o_push_data
);

    logic [mf3_pkg::SZ_COL_W-1:0] r_width;
    logic [mf3_pkg::SZ_COL_W-1:0] n_width;
    logic [mf3_pkg::SZ_ROW_W-1:0] r_height;
    logic [mf3_pkg::SZ_ROW_W-1:0] n_height;
    logic [mf3_pkg::IMG_WIDTH_W-1:0]  w_cfg_w;
    logic [mf3_pkg::IMG_HEIGHT_W-1:0] w_cfg_h;

    logic [mf3_pkg::COL_W-1:0] r_col;
    logic [mf3_pkg::COL_W-1:0] n_col;
    logic [mf3_pkg::ROW_W-1:0] r_row;
    logic [mf3_pkg::ROW_W-1:0] n_row;
    logic [mf3_pkg::COL_W-1:0] w_pos_col;
    logic [mf3_pkg::ROW_W-1:0] w_pos_row;
    logic [mf3_pkg::SZ_COL_W-1:0] w_col_inc;
    logic [mf3_pkg::SZ_ROW_W-1:0] w_row_inc;
    logic w_accept;
    logic w_emit;
    logic w_last;

    logic                      r_s1_valid;
    logic [mf3_pkg::COL_W-1:0] r_s1_col;
    mf3_pkg::t_pix             r_s1_pix;
    logic                      r_s1_emit;
    logic                      r_s1_last;

    logic                      r_byp_valid;
    logic [mf3_pkg::COL_W-1:0] r_byp_col;
    logic [mf3_pkg::LS_W-1:0]  r_byp_data;

    logic [mf3_pkg::LS_W-1:0]  w_ram_q;
    logic [mf3_pkg::LS_W-1:0]  w_stored;
    logic [mf3_pkg::LS_W-1:0]  w_wdata;
    mf3_pkg::t_pix             w_top;
    mf3_pkg::t_pix             w_mid;

    mf3_pkg::t_pix r_win [6];

    // configuration, stored already clamped
    assign w_cfg_w = i_cfg_data[mf3_pkg::IMG_WIDTH_W-1:0];
    assign w_cfg_h = i_cfg_data[mf3_pkg::IMG_HEIGHT_W-1:0];

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                mf3_pkg::CFG_IMAGE_WIDTH: begin
                    if (w_cfg_w < mf3_pkg::MIN_SIZE) begin
                        n_width = mf3_pkg::SZ_COL_W'(mf3_pkg::MIN_SIZE);
                    end else if (w_cfg_w > mf3_pkg::MAX_WIDTH) begin
                        n_width = mf3_pkg::SZ_COL_W'(mf3_pkg::MAX_WIDTH);
                    end else begin
                        n_width = mf3_pkg::SZ_COL_W'(w_cfg_w);
                    end
                end
                mf3_pkg::CFG_IMAGE_HEIGHT: begin
                    if (w_cfg_h < mf3_pkg::MIN_SIZE) begin
                        n_height = mf3_pkg::SZ_ROW_W'(mf3_pkg::MIN_SIZE);
                    end else if (w_cfg_h > mf3_pkg::MAX_HEIGHT) begin
                        n_height = mf3_pkg::SZ_ROW_W'(mf3_pkg::MAX_HEIGHT);
                    end else begin
                        n_height = mf3_pkg::SZ_ROW_W'(w_cfg_h);
                    end
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // stage 0: position and line store read
    assign o_ready  = (32'(i_q_count) + 32'(r_s1_valid)) < mf3_pkg::QUEUE_DEPTH;
    assign w_accept = i_valid && o_ready;

    assign w_pos_col = i_frame_start ? '0 : r_col;
    assign w_pos_row = i_frame_start ? '0 : r_row;
    assign w_col_inc = {1'b0, w_pos_col} + mf3_pkg::SZ_COL_W'(1);
    assign w_row_inc = {1'b0, w_pos_row} + mf3_pkg::SZ_ROW_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_inc >= r_width) begin
                n_col = '0;
                n_row = (w_row_inc >= r_height) ? '0 : w_row_inc[mf3_pkg::ROW_W-1:0];
            end else begin
                n_col = w_col_inc[mf3_pkg::COL_W-1:0];
                n_row = w_pos_row;
            end
        end
    end

    assign w_emit = (w_pos_row >= mf3_pkg::ROW_W'(2)) && (w_pos_col >= mf3_pkg::COL_W'(2));
    assign w_last = ({1'b0, w_pos_row} == (r_height - mf3_pkg::SZ_ROW_W'(1)))
                 && ({1'b0, w_pos_col} == (r_width - mf3_pkg::SZ_COL_W'(1)));

    // line store pair: upper half two lines back, lower half previous line
    mf3_ram #(
        .WIDTH (mf3_pkg::LS_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_pos_col),
        .o_rdata (w_ram_q)
    );

    // stage 1: forward a write to the same column from the cycle before
    assign w_stored = (r_byp_valid && (r_byp_col == r_s1_col)) ? r_byp_data : w_ram_q;
    assign w_top    = w_stored[mf3_pkg::LS_W-1:mf3_pkg::PIX_W];
    assign w_mid    = w_stored[mf3_pkg::PIX_W-1:0];
    assign w_wdata  = {w_mid, r_s1_pix};

    always_comb begin
        o_push_data.last  = r_s1_last;
        for (int k = 0; k < 6; k++) begin
            o_push_data.px[k] = r_win[k];
        end
        o_push_data.px[6] = w_top;
        o_push_data.px[7] = w_mid;
        o_push_data.px[8] = r_s1_pix;
    end
    assign o_push = r_s1_valid && r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= mf3_pkg::SZ_COL_W'(mf3_pkg::WIDTH_RESET);
            r_height    <= mf3_pkg::SZ_ROW_W'(mf3_pkg::HEIGHT_RESET);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1_valid  <= w_accept;
            r_byp_valid <= r_s1_valid;
            if (r_s1_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k] <= r_win[k+3];
                end
                r_win[3] <= w_top;
                r_win[4] <= w_mid;
                r_win[5] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col  <= w_pos_col;
            r_s1_pix  <= i_pix;
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
        end
        r_byp_col  <= r_s1_col;
        r_byp_data <= w_wdata;
    end

    `MF3_ASSERT_NEXT(a_accept_reaches_s1, i_clk, i_rst_n, w_accept, r_s1_valid, "accepted beat lost before line store stage")
    `MF3_ASSERT_SAME(a_last_is_interior, i_clk, i_rst_n, r_s1_valid && r_s1_last, r_s1_emit, "frame end marked on a border position")

endmodule

// ===== hw/rtl/mf3_queue.sv =====
// short window queue between front and back ends
`include "median_filter_3x3_rgb_top_macros.svh"

module mf3_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mf3_pkg::t_win               i_push_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output mf3_pkg::t_win               o_data,
    output logic [mf3_pkg::QCNT_W-1:0]  o_count
);

    mf3_pkg::t_win               r_mem [mf3_pkg::QUEUE_DEPTH];
    logic [mf3_pkg::QPTR_W-1:0]  r_wptr;
    logic [mf3_pkg::QPTR_W-1:0]  n_wptr;
    logic [mf3_pkg::QPTR_W-1:0]  r_rptr;
    logic [mf3_pkg::QPTR_W-1:0]  n_rptr;
    logic [mf3_pkg::QCNT_W-1:0]  r_count;
    logic [mf3_pkg::QCNT_W-1:0]  n_count;
    logic                        w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == mf3_pkg::QPTR_W'(mf3_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_wptr + mf3_pkg::QPTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == mf3_pkg::QPTR_W'(mf3_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_rptr + mf3_pkg::QPTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + mf3_pkg::QCNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - mf3_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    `MF3_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= mf3_pkg::QUEUE_DEPTH, "queue fill beyond depth")
    `MF3_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, r_count < mf3_pkg::QUEUE_DEPTH, "window pushed into full queue")

endmodule

// ===== hw/rtl/mf3_back.sv =====
// back end: three stage median network per channel, the last stage being the output register
`include "median_filter_3x3_rgb_top_macros.svh"

module mf3_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  mf3_pkg::t_win           i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output mf3_pkg::t_pix           o_med,
    output logic                    o_last
);

    logic w_rdy_a;
    logic w_rdy_b;
    logic w_rdy_c;

    logic                r_va;
    logic                r_a_last;
    mf3_pkg::t_trio      r_a_sort [mf3_pkg::N_CH][3];

    logic                r_vb;
    logic                r_b_last;
    mf3_pkg::t_trio      r_b_trio [mf3_pkg::N_CH];

    logic                r_vc;
    logic                r_c_last;
    mf3_pkg::t_pix       r_c_med;

    assign w_rdy_c = !r_vc || i_ready;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
            if (w_rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // sort each column
        if (w_rdy_a && i_valid) begin
            r_a_last <= i_data.last;
            for (int ch = 0; ch < mf3_pkg::N_CH; ch++) begin
                for (int k = 0; k < 3; k++) begin
                    r_a_sort[ch][k] <= mf3_pkg::sort3(i_data.px[3*k][ch],
                                                      i_data.px[3*k+1][ch],
                                                      i_data.px[3*k+2][ch]);
                end
            end
        end
        // max of lows, median of middles, min of highs
        if (w_rdy_b && r_va) begin
            r_b_last <= r_a_last;
            for (int ch = 0; ch < mf3_pkg::N_CH; ch++) begin
                r_b_trio[ch][0] <= mf3_pkg::max3(r_a_sort[ch][0][0], r_a_sort[ch][1][0],
                                                 r_a_sort[ch][2][0]);
                r_b_trio[ch][1] <= mf3_pkg::med3(r_a_sort[ch][0][1], r_a_sort[ch][1][1],
                                                 r_a_sort[ch][2][1]);
                r_b_trio[ch][2] <= mf3_pkg::min3(r_a_sort[ch][0][2], r_a_sort[ch][1][2],
                                                 r_a_sort[ch][2][2]);
            end
        end
        if (w_rdy_c && r_vb) begin
            r_c_last <= r_b_last;
            for (int ch = 0; ch < mf3_pkg::N_CH; ch++) begin
                r_c_med[ch] <= mf3_pkg::med3(r_b_trio[ch][0], r_b_trio[ch][1],
                                             r_b_trio[ch][2]);
            end
        end
    end

    assign o_valid = r_vc;
    assign o_med   = r_c_med;
    assign o_last  = r_c_last;

    `MF3_ASSERT_NEXT(a_pop_enters_sort, i_clk, i_rst_n, i_valid && w_rdy_a, r_va, "window taken from queue but not in sort stage")

endmodule

// ===== hw/rtl/median_filter_3x3_rgb_top.sv =====
// 3x3 rgb median filter top level
// Takes one RGB pixel per clock in raster order, unless stalled, and returns, for
// every interior position, the per-channel median of its 3x3 neighbourhood; border
// positions give no output beat. A beat with tuser set is row 0, column 0; the
// position otherwise advances by itself and wraps at the configured width and
// height, which are clamped to 3..1024 and 3..2048. Sustained rate is one pixel
// per clock while the output is not stalled, set by the line store pair, read
// once and written once per pixel. An input beat passes through the line store
// and window stage, the queue and the three median network stages. The four-entry
// queue between front and network lets either side stall alone. The line stores
// are not cleared after reset; write the size registers only while no pixel is in
// flight.
module median_filter_3x3_rgb_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // pix_blue, pix_green, pix_red
    input  logic                            s_axis_tuser,  // frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // med_blue, med_green, med_red
    output logic                            m_axis_tlast   // frame_end
);

    logic                          w_push;
    mf3_pkg::t_win                 w_push_data;
    logic                          w_q_valid;
    logic                          w_q_ready;
    mf3_pkg::t_win                 w_q_data;
    logic [mf3_pkg::QCNT_W-1:0]    w_q_count;
    mf3_pkg::t_pix                 w_med;

    mf3_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pix         (mf3_pkg::t_pix'(s_axis_tdata)),
        .i_frame_start (s_axis_tuser),
        .i_q_count     (w_q_count),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    mf3_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_valid     (w_q_valid),
        .i_ready     (w_q_ready),
        .o_data      (w_q_data),
        .o_count     (w_q_count)
    );

    mf3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_data  (w_q_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_med   (w_med),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = 24'(w_med);

endmodule
